### design/sxfb_pkg.sv
`default_nettype none

package sxfb_pkg;

   localparam int SCREEN_ROWS    = 32;
   localparam int SCREEN_COLUMNS = 64;

   // Address of one display row, and a sum wide enough to hold start row plus offset
   // without wrapping past any screen height in range.
   localparam int ROW_AW    = $clog2(SCREEN_ROWS);
   localparam int ROW_SUM_W = 7;

   localparam int KIND_W    = 2;
   localparam int COLUMN_W  = 6;
   localparam int ROW_W     = 5;
   localparam int OFFSET_W  = 4;
   localparam int SPRITE_W  = 8;
   localparam int PIXELS_W  = 64;

   localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   localparam logic RSP_COLLISION = 1'b0;
   localparam logic RSP_ROW       = 1'b1;

   typedef logic [SCREEN_COLUMNS-1:0] row_word_type;

   // One cycle's command to the row store.
   typedef struct packed {
      logic                  wr_en;
      logic                  clear;
      logic [ROW_AW-1:0]     addr;
      row_word_type          data;
   } store_cmd_type;

   // Places the sprite byte at its start column, MSB leftmost; bits past the
   // right edge land in the top bits of the wide word and are dropped.
   function automatic row_word_type sprite_pattern(input logic [SPRITE_W-1:0] bits,
                                                   input logic [COLUMN_W-1:0] column);
      logic [SPRITE_W-1:0]                rev;
      logic [SCREEN_COLUMNS+SPRITE_W-1:0] wide;
      for (int i = 0; i < SPRITE_W; i++) begin
         rev[i] = bits[SPRITE_W-1-i];
      end
      wide = {{SCREEN_COLUMNS{1'b0}}, rev} << column;
      return wide[SCREEN_COLUMNS-1:0];
   endfunction

endpackage

`default_nettype wire

### design/sxfb_if.sv
`default_nettype none

interface sxfb_req_if import sxfb_pkg::*;;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [COLUMN_W-1:0] start_column;
   logic [ROW_W-1:0]    start_row;
   logic [OFFSET_W-1:0] row_offset;
   logic [SPRITE_W-1:0] sprite_byte;
   logic                last_row;
   logic [ROW_W-1:0]    read_row;

   modport source (output valid, kind, start_column, start_row, row_offset, sprite_byte,
                   last_row, read_row, input ready);
   modport sink   (input valid, kind, start_column, start_row, row_offset, sprite_byte,
                   last_row, read_row, output ready);
endinterface

interface sxfb_rsp_if import sxfb_pkg::*;;
   logic                valid;
   logic                ready;
   logic                result_kind;
   logic                collision;
   logic [PIXELS_W-1:0] row_pixels;

   modport source (output valid, result_kind, collision, row_pixels, input ready);
   modport sink   (input valid, result_kind, collision, row_pixels, output ready);
endinterface

`default_nettype wire

### design/sprite_xor_framebuffer_core.sv
// A result item passes through the working stage and then the output register, where
// it is held until taken; a full output register that is not taken stalls the stage.
// Throughput: one item per cycle while the output is not stalled, set by the single
// read port and write port of the row store; a row written in one cycle is forwarded
// to the item read in that cycle. A clear item only drops the per-row valid bits.
// Reset is synchronous: it empties both stages, drops every row valid bit and clears
// the collision flag, so the display reads as all pixels off at once.
`default_nettype none

module sprite_xor_framebuffer_core import sxfb_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   sxfb_req_if.sink      req_chan,
   sxfb_rsp_if.source    rsp_chan
);

   // Item accepted this cycle, and the row it needs from the store.
   logic                 accept;
   logic [ROW_SUM_W-1:0] draw_row_sum;
   logic [ROW_SUM_W-1:0] read_row_ext;
   logic [ROW_SUM_W-1:0] target_row;
   logic                 target_in_range;

   // Working stage: the item whose row is coming out of the store this cycle.
   logic                 s1_valid_ff, s1_valid_in;
   logic [KIND_W-1:0]    s1_kind_ff;
   logic                 s1_in_range_ff;
   logic [ROW_AW-1:0]    s1_addr_ff;
   row_word_type         s1_pattern_ff;
   logic                 s1_first_ff;
   logic                 s1_last_ff;

   // Forwarding of the write or clear that happened in the cycle of the read.
   logic                 fwd_hit_ff;
   logic                 fwd_clear_ff;
   row_word_type         fwd_data_ff;

   logic                 collision_seen_ff, collision_seen_in;

   // Output register.
   logic                 out_valid_ff, out_valid_in;
   logic                 out_kind_ff;
   logic                 out_collision_ff;
   row_word_type         out_row_ff;

   row_word_type         rd_data;
   row_word_type         old_row;
   logic                 s1_is_draw;
   logic                 s1_has_rsp;
   logic                 s1_stall;
   logic                 s1_fire;
   logic                 collision_new;
   logic                 out_load;
   store_cmd_type        store_cmd;

   // Draw rows are start row plus offset; rows below the screen are dropped.
   assign draw_row_sum = ROW_SUM_W'(req_chan.start_row) + ROW_SUM_W'(req_chan.row_offset);
   assign read_row_ext = ROW_SUM_W'(req_chan.read_row);
   assign target_row   = (req_chan.kind == KIND_READ) ? read_row_ext : draw_row_sum;
   assign target_in_range = target_row < ROW_SUM_W'(SCREEN_ROWS);

   // The working stage moves on unless it has a result and the output register
   // is still full and not being taken.
   assign s1_is_draw = s1_kind_ff == KIND_DRAW;
   assign s1_has_rsp = (s1_is_draw && s1_last_ff) || (s1_kind_ff == KIND_READ);
   assign s1_stall   = s1_valid_ff && s1_has_rsp && out_valid_ff && !rsp_chan.ready;
   assign s1_fire    = s1_valid_ff && !s1_stall;

   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign accept         = req_chan.valid && req_chan.ready;

   assign s1_valid_in = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff     <= req_chan.kind;
         s1_in_range_ff <= target_in_range;
         s1_addr_ff     <= target_row[ROW_AW-1:0];
         s1_pattern_ff  <= sprite_pattern(req_chan.sprite_byte, req_chan.start_column);
         s1_first_ff    <= req_chan.row_offset == '0;
         s1_last_ff     <= req_chan.last_row;
         // The store read in this cycle misses what the working stage writes now.
         fwd_hit_ff     <= store_cmd.wr_en && (store_cmd.addr == target_row[ROW_AW-1:0]);
         fwd_clear_ff   <= store_cmd.clear;
         fwd_data_ff    <= store_cmd.data;
      end
   end

   sxfb_row_store u_row_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (target_row[ROW_AW-1:0]),
      .rd_data (rd_data),
      .cmd     (store_cmd)
   );

   always_comb begin
      if (fwd_clear_ff) begin
         old_row = '0;
      end else if (fwd_hit_ff) begin
         old_row = fwd_data_ff;
      end else begin
         old_row = rd_data;
      end
   end

   // Read, XOR and write back happen in the working stage; the flag restarts on the first sprite row.
   assign collision_new = (s1_first_ff ? 1'b0 : collision_seen_ff) |
                          (s1_in_range_ff && |(old_row & s1_pattern_ff));

   always_comb begin
      store_cmd.wr_en = s1_fire && s1_is_draw && s1_in_range_ff;
      store_cmd.clear = s1_fire && (s1_kind_ff == KIND_CLEAR);
      store_cmd.addr  = s1_addr_ff;
      store_cmd.data  = old_row ^ s1_pattern_ff;
   end

   assign collision_seen_in = (s1_fire && s1_is_draw) ? collision_new : collision_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         collision_seen_ff <= 1'b0;
      end else begin
         collision_seen_ff <= collision_seen_in;
      end
   end

   // Output register: a finished result waits here while the next item works.
   assign out_load     = s1_fire && s1_has_rsp;
   assign out_valid_in = out_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (s1_is_draw) begin
            out_kind_ff      <= RSP_COLLISION;
            out_collision_ff <= collision_new;
            out_row_ff       <= '0;
         end else begin
            out_kind_ff      <= RSP_ROW;
            out_collision_ff <= 1'b0;
            out_row_ff       <= s1_in_range_ff ? old_row : '0;
         end
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.result_kind = out_kind_ff;
   assign rsp_chan.collision   = out_collision_ff;
   assign rsp_chan.row_pixels  = PIXELS_W'(out_row_ff);

   // A write and a clear never come from the same item.
   assert property (@(posedge clock) disable iff (reset)
      !(store_cmd.wr_en && store_cmd.clear))
      else $error("row store write and clear in the same cycle");

   // Only an in-range draw in the working stage writes the store.
   assert property (@(posedge clock) disable iff (reset)
      store_cmd.wr_en |-> (s1_valid_ff && s1_is_draw && s1_in_range_ff))
      else $error("row store written without an in-range draw");

   // A stalled working stage keeps its item and takes no new one.
   assert property (@(posedge clock) disable iff (reset)
      s1_stall |-> (!accept ##1 (s1_valid_ff && $stable(s1_addr_ff))))
      else $error("working stage lost its item during a stall");

   // A result is only loaded into a free or draining output register.
   assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || rsp_chan.ready))
      else $error("output register overwritten before it was taken");

   // Every loaded result shows up as valid on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      out_load |=> out_valid_ff)
      else $error("loaded result not presented");

endmodule

`default_nettype wire

### design/sxfb_row_store.sv
`default_nettype none

module sxfb_row_store import sxfb_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          rd_en,
   input  wire logic [ROW_AW-1:0] rd_addr,
   output row_word_type       rd_data,
   input  wire store_cmd_type cmd
);

   row_word_type             mem_ff [SCREEN_ROWS];
   logic [SCREEN_ROWS-1:0]   row_valid_ff;
   logic [SCREEN_ROWS-1:0]   row_valid_in;
   row_word_type             rd_word_ff;
   logic                     rd_valid_ff;

   // A row that is not marked valid reads as all pixels off, so reset and the
   // clear item only drop the valid bits.
   always_comb begin
      row_valid_in = row_valid_ff;
      if (cmd.clear) begin
         row_valid_in = '0;
      end else if (cmd.wr_en) begin
         row_valid_in[cmd.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.addr] <= cmd.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff  <= mem_ff[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire
